FILE: hdl/dess_pkg.sv
// shared types, constants and codes for the three-axis double exponential smoother
// no dependencies
package dess_pkg;

    localparam int SAMPLE_BITS    = 32;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
    localparam int NUM_AXES       = 3;
    localparam int AXIS_W         = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = GAIN_W;
    localparam int AXES_W         = 2;

    // blend operands are one bit wider than a sample (level plus trend)
    localparam int OPER_W = SAMPLE_BITS + 1;

    localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

    // reset gains: 0.4 and 0.5 in unsigned q1.GAIN_FRAC_BITS
    localparam int LEVEL_GAIN_RST_I = (2 * (2 ** GAIN_FRAC_BITS)) / 5;
    localparam int TREND_GAIN_RST_I = 2 ** (GAIN_FRAC_BITS - 1);
    localparam logic [GAIN_W-1:0] LEVEL_GAIN_RST = GAIN_W'(LEVEL_GAIN_RST_I);
    localparam logic [GAIN_W-1:0] TREND_GAIN_RST = GAIN_W'(TREND_GAIN_RST_I);
    localparam logic [AXES_W-1:0] AXES_RST       = AXES_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_GAIN  = 2'd0,
        CFG_TREND_GAIN  = 2'd1,
        CFG_AXES_IN_USE = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_LVL_MUL,
        ST_LVL_FIN,
        ST_TRD_MUL,
        ST_TRD_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_x;
        logic signed [SAMPLE_BITS-1:0] sample_y;
        logic signed [SAMPLE_BITS-1:0] sample_z;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smoothed_x;
        logic signed [SAMPLE_BITS-1:0] smoothed_y;
        logic signed [SAMPLE_BITS-1:0] smoothed_z;
    } t_out_word;

    // sequencer controls towards the datapath
    typedef struct packed {
        logic in_ready;
        logic blend_en;
        logic use_trend;
        logic take_lvl;
        logic take_trd;
        logic load_out;
    } t_ctrl;

endpackage

FILE: hdl/dess_blend.sv
// shared blend unit: w*a + (one-w)*b, rounded half up and saturated to a sample
// registered multiply, finishing add/round/saturate read from the product register
// depends on dess_pkg
module dess_blend (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic        [dess_pkg::GAIN_W-1:0]      i_gain,
    input  logic signed [dess_pkg::OPER_W-1:0]      i_a,
    input  logic signed [dess_pkg::OPER_W-1:0]      i_b,
    output logic signed [dess_pkg::SAMPLE_BITS-1:0] o_res
);
    import dess_pkg::*;

    localparam int DIFF_W = OPER_W + 1;
    localparam int PROD_W = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int Q_W    = ACC_W - GAIN_FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (GAIN_FRAC_BITS - 1);

    logic signed [DIFF_W-1:0] w_diff;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [OPER_W-1:0] r_b;
    logic        [ACC_W-1:0]  w_acc;
    logic        [Q_W-1:0]    w_q;
    logic                     w_ovf;

    // b*one + w*(a-b) is the same blend with one product
    assign w_diff = {i_a[OPER_W-1], i_a} - {i_b[OPER_W-1], i_b};
    assign n_prod = $signed({1'b0, i_gain}) * w_diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_b    <= i_b;
        end
    end

    assign w_acc = {{(ACC_W - OPER_W - GAIN_FRAC_BITS){r_b[OPER_W-1]}}, r_b,
                    {GAIN_FRAC_BITS{1'b0}}}
                 + {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod}
                 + HALF;

    // floor shift, then saturate when the top bits disagree
    assign w_q   = w_acc[ACC_W-1:GAIN_FRAC_BITS];
    assign w_ovf = !((&w_q[Q_W-1:SAMPLE_BITS-1]) || !(|w_q[Q_W-1:SAMPLE_BITS-1]));

    always_comb begin
        if (!w_ovf) begin
            o_res = w_q[SAMPLE_BITS-1:0];
        end else if (w_q[Q_W-1]) begin
            o_res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            o_res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

FILE: hdl/dess_seq.sv
// sequencer of the smoother: walks the axes and the two blends of each smoothed axis
// depends on dess_pkg
module dess_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_out_stall,
    input  logic                        i_primed,
    input  logic                        i_out_vld,
    input  logic [dess_pkg::AXIS_W-1:0] i_axis,
    input  logic [dess_pkg::AXES_W-1:0] i_axes,
    output dess_pkg::t_state            o_state,
    output dess_pkg::t_ctrl             o_ctrl
);
    import dess_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_last;
    logic   w_in_use;
    logic   w_out_free;

    assign w_last     = (i_axis == AXIS_W'(NUM_AXES - 1));
    assign w_in_use   = (i_axis < i_axes);
    assign w_out_free = !i_out_vld || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_primed ? ST_SEL : ST_DONE;
                end
            end
            ST_SEL: begin
                if (w_in_use) begin
                    n_state = ST_LVL_MUL;
                end else if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_LVL_MUL: n_state = ST_LVL_FIN;
            ST_LVL_FIN: n_state = ST_TRD_MUL;
            ST_TRD_MUL: n_state = ST_TRD_FIN;
            ST_TRD_FIN: n_state = w_last ? ST_DONE : ST_SEL;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            ST_IDLE:    o_ctrl.in_ready = 1'b1;
            ST_LVL_MUL: o_ctrl.blend_en = 1'b1;
            ST_LVL_FIN: o_ctrl.take_lvl = 1'b1;
            ST_TRD_MUL: begin
                o_ctrl.blend_en  = 1'b1;
                o_ctrl.use_trend = 1'b1;
            end
            ST_TRD_FIN: o_ctrl.take_trd = 1'b1;
            ST_DONE:    o_ctrl.load_out = w_out_free;
            default:    o_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

FILE: hdl/double_exponential_smoother_3axis.sv
// top level of the three-axis holt double exponential smoother
// depends on dess_pkg, dess_blend and dess_seq
//
// use of the block
// - input channel: i_in_valid / o_in_stall carry one word of three signed q16.16
//   samples; a word is taken at an edge with valid high and stall low
// - output channel: o_out_valid / i_out_stall carry one word of three smoothed
//   samples per input word, in order
// - config channel: i_cfg_valid / o_cfg_ready with a register index and data;
//   ready is always high, index 0 level gain, 1 trend gain, 2 axes in use,
//   other indexes are dropped; write only while the block is idle
// - the first word after reset passes straight through: it is held in the result
//   registers and moves into the output register in the done step; later words go
//   through a select step per axis and the two blends of each smoothed axis
// - flow: one word at a time; the next word is taken only after the result has moved
//   into the output register. The single shared multiplier serves two blends per
//   smoothed axis, each with a multiply step and a round/saturate step
// - reset (synchronous, active low) restores the default gains and axis count
//   and forgets the first sample, so the next word primes level and trend again
// - a stalled receiver holds the result in the output register; one more word
//   is worked on meanwhile and waits finished until the register frees
module double_exponential_smoother_3axis (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dess_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dess_pkg::t_out_word               o_out_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dess_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dess_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dess_pkg::*;

    // configuration registers
    logic [GAIN_W-1:0] r_level_gain;
    logic [GAIN_W-1:0] r_trend_gain;
    logic [AXES_W-1:0] r_axes;

    // per-axis state, loaded by the first word before it is ever read
    logic signed [SAMPLE_BITS-1:0] r_level [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] r_trend [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] r_samp  [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] r_res   [NUM_AXES];
    logic signed [SAMPLE_BITS-1:0] w_in    [NUM_AXES];

    logic              r_primed;
    logic [AXIS_W-1:0] r_axis;
    logic              r_out_vld;
    t_out_word         r_out_word;

    t_state            w_state;
    t_ctrl             w_ctrl;
    logic              w_in_acc;

    // blend operands
    logic        [GAIN_W-1:0]      w_alpha;
    logic        [GAIN_W-1:0]      w_gamma;
    logic        [GAIN_W-1:0]      w_gain;
    logic signed [OPER_W-1:0]      w_a;
    logic signed [OPER_W-1:0]      w_b;
    logic signed [SAMPLE_BITS-1:0] w_blend;
    logic signed [SAMPLE_BITS-1:0] w_lv;
    logic signed [SAMPLE_BITS-1:0] w_tr;
    logic signed [SAMPLE_BITS-1:0] w_sm;
    logic signed [SAMPLE_BITS-1:0] w_sp;

    assign w_in[0] = i_in_word.sample_x;
    assign w_in[1] = i_in_word.sample_y;
    assign w_in[2] = i_in_word.sample_z;

    assign o_in_stall  = !w_ctrl.in_ready;
    assign w_in_acc    = i_in_valid && w_ctrl.in_ready;
    assign o_cfg_ready = 1'b1;

    // gains above one act as one
    assign w_alpha = (r_level_gain > GAIN_ONE) ? GAIN_ONE : r_level_gain;
    assign w_gamma = (r_trend_gain > GAIN_ONE) ? GAIN_ONE : r_trend_gain;

    assign w_lv = r_level[r_axis];
    assign w_tr = r_trend[r_axis];
    assign w_sm = r_res[r_axis];
    assign w_sp = r_samp[r_axis];

    // level blend: alpha, sample, level + trend
    // trend blend: gamma, new smoothed - old level, trend
    always_comb begin
        if (w_ctrl.use_trend) begin
            w_gain = w_gamma;
            w_a    = {w_sm[SAMPLE_BITS-1], w_sm} - {w_lv[SAMPLE_BITS-1], w_lv};
            w_b    = {w_tr[SAMPLE_BITS-1], w_tr};
        end else begin
            w_gain = w_alpha;
            w_a    = {w_sp[SAMPLE_BITS-1], w_sp};
            w_b    = {w_lv[SAMPLE_BITS-1], w_lv} + {w_tr[SAMPLE_BITS-1], w_tr};
        end
    end

    dess_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (w_ctrl.blend_en),
        .i_gain (w_gain),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_res  (w_blend)
    );

    dess_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_primed    (r_primed),
        .i_out_vld   (r_out_vld),
        .i_axis      (r_axis),
        .i_axes      (r_axes),
        .o_state     (w_state),
        .o_ctrl      (w_ctrl)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_gain <= LEVEL_GAIN_RST;
            r_trend_gain <= TREND_GAIN_RST;
            r_axes       <= AXES_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEVEL_GAIN:  r_level_gain <= i_cfg_data;
                CFG_TREND_GAIN:  r_trend_gain <= i_cfg_data;
                CFG_AXES_IN_USE: r_axes       <= i_cfg_data[AXES_W-1:0];
                default:         ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed  <= 1'b0;
            r_axis    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_primed <= 1'b1;
                r_axis   <= '0;
            end else if ((w_state == ST_SEL && r_axis >= r_axes) || w_ctrl.take_trd) begin
                if (r_axis != AXIS_W'(NUM_AXES - 1)) begin
                    r_axis <= r_axis + AXIS_W'(1);
                end
            end
            if (w_ctrl.load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // per-axis datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_samp[k] <= w_in[k];
                // first word primes level and trend and passes through
                if (!r_primed) begin
                    r_level[k] <= w_in[k];
                    r_trend[k] <= w_in[k];
                    r_res[k]   <= w_in[k];
                end
            end
        end
        if (w_state == ST_SEL && r_axis >= r_axes) begin
            r_res[r_axis] <= w_sp;
        end
        if (w_ctrl.take_lvl) begin
            r_res[r_axis] <= w_blend;
        end
        if (w_ctrl.take_trd) begin
            r_trend[r_axis] <= w_blend;
            r_level[r_axis] <= w_sm;
        end
        if (w_ctrl.load_out) begin
            r_out_word.smoothed_x <= r_res[0];
            r_out_word.smoothed_y <= r_res[1];
            r_out_word.smoothed_z <= r_res[2];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // a taken word closes the input until its result is in the output register
    a_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after a word was taken");

    // every word leaves the block primed
    a_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_primed)
        else $error("not primed after a word");

    // a new result only comes from the finishing step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_state == ST_DONE))
        else $error("result loaded outside the finishing step");

    // the axis counter never leaves the axis range
    a_axis_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axis != AXIS_W'(NUM_AXES))
        else $error("axis counter out of range");

endmodule
